/* hdl/assert_macros.svh */
// Assertion macros used by the controller RTL of the lightmap texel combiner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define LTC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define LTC_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `LTC_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

/* hdl/ltc_pkg.sv */
// Package with types and constants of the lightmap texel combiner.
`timescale 1ns / 1ps
`default_nettype none

package ltc_pkg;

    localparam int unsigned ADDR_W = 4;
    localparam int unsigned DATA_W = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_OUT_SCALE  = 2'd0;
    localparam logic [1:0] REG_INVERT     = 2'd1;
    localparam logic [1:0] REG_FULLBRIGHT = 2'd2;

    localparam logic [10:0] OUT_SCALE_RST = 11'd512;

    localparam logic [31:0] START_FULL = 32'h0000_FF00;
    localparam logic [31:0] NORM_LIMIT = 32'h00FF_8000;
    localparam logic [31:0] SCALED_CAP = 32'hFF80_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_DYN,
        S_SCALE,
        S_MAX,
        S_DIV,
        S_NORM,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       cap_in;
        logic       add_prod;
        logic       add_dyn;
        logic       scale;
        logic       load_div;
        logic       div_step;
        logic       norm;
        logic       load_out;
        logic [1:0] ch;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic need_norm;
    } t_dp_status;

    typedef struct packed {
        logic [10:0] out_scale;
        logic        invert;
        logic        fullbright;
        logic        fb_load;
        logic        fb_new;
    } t_cfg;

endpackage

`default_nettype wire

/* hdl/ltc_if.sv */
// Handshake channel interfaces for layer items in and texel items out.
`timescale 1ns / 1ps
`default_nettype none

interface ltc_layer_if;
    logic        valid;
    logic        ready;
    logic [7:0]  sample_r;
    logic [7:0]  sample_g;
    logic [7:0]  sample_b;
    logic [11:0] style_scale;
    logic [23:0] dyn_r;
    logic [23:0] dyn_g;
    logic [23:0] dyn_b;
    logic        last_layer;

    modport source (
        output valid, sample_r, sample_g, sample_b, style_scale,
               dyn_r, dyn_g, dyn_b, last_layer,
        input  ready
    );
    modport sink (
        input  valid, sample_r, sample_g, sample_b, style_scale,
               dyn_r, dyn_g, dyn_b, last_layer,
        output ready
    );
endinterface

interface ltc_texel_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_r;
    logic [7:0] out_g;
    logic [7:0] out_b;

    modport source (output valid, out_r, out_g, out_b, input ready);
    modport sink (input valid, out_r, out_g, out_b, output ready);
endinterface

`default_nettype wire

/* hdl/ltc_ctrl.sv */
// Controller state machine of the lightmap texel combiner.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ltc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    input  wire ltc_pkg::t_dp_status i_status,
    output ltc_pkg::t_dp_cmd        o_cmd
);
    import ltc_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and step counter
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_ACC;
            S_ACC:   n_state = i_status.last ? S_DYN : S_IDLE;
            S_DYN:   n_state = S_SCALE;
            S_SCALE: if (r_cnt == 3'd2) n_state = S_MAX;
            S_MAX:   n_state = i_status.need_norm ? S_DIV : S_EMIT;
            S_DIV:   if (r_cnt == 3'd7) n_state = S_NORM;
            S_NORM:  if (r_cnt == 3'd2) n_state = S_EMIT;
            S_EMIT:  if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        n_cnt = (n_state != r_state) ? 3'd0 : r_cnt + 3'd1;
    end

    // Outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.ch       = r_cnt[1:0];
        o_in_ready     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.cap_in = i_in_valid;
            end
            S_ACC:   o_cmd.add_prod = 1'b1;
            S_DYN:   o_cmd.add_dyn  = 1'b1;
            S_SCALE: o_cmd.scale    = 1'b1;
            S_MAX:   o_cmd.load_div = 1'b1;
            S_DIV:   o_cmd.div_step = 1'b1;
            S_NORM:  o_cmd.norm     = 1'b1;
            S_EMIT:  o_cmd.load_out = !r_out_valid || i_out_ready;
            default: o_cmd = '0;
        endcase
        n_out_valid = o_cmd.load_out ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
        o_out_valid = r_out_valid;
    end

    `LTC_ASSERT(a_accept_to_acc, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_state == S_ACC), "accepted item did not advance to accumulate")
    `LTC_ASSERT(a_norm_to_div, i_clk, i_rst_n, (r_state == S_MAX && i_status.need_norm) |=> (r_state == S_DIV), "normalize request did not start the divide")
    `LTC_ASSERT(a_div_len, i_clk, i_rst_n, (r_state == S_DIV && r_cnt == 3'd7) |=> (r_state == S_NORM && r_cnt == 3'd0), "divide did not end after eight steps")
    `LTC_ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, o_cmd.load_out && r_out_valid && !i_out_ready, "pending texel item overwritten")

endmodule

`default_nettype wire

/* hdl/ltc_dp.sv */
// Datapath of the lightmap texel combiner: accumulate, scale, divide, emit.
`timescale 1ns / 1ps
`default_nettype none

module ltc_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ltc_pkg::t_dp_cmd    i_cmd,
    output ltc_pkg::t_dp_status      o_status,
    input  wire ltc_pkg::t_cfg       i_cfg,
    input  wire logic [7:0]          i_sample [3],
    input  wire logic [11:0]         i_style_scale,
    input  wire logic [23:0]         i_dyn [3],
    input  wire logic                i_last,
    output logic [7:0]               o_out [3]
);
    import ltc_pkg::*;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    logic [19:0] r_prod [3];
    logic [23:0] r_dyn  [3];
    logic        r_last;
    logic [31:0] r_acc  [3];
    logic [31:0] r_scl  [3];
    logic [31:0] r_rem;
    logic [39:0] r_dsh;
    logic [7:0]  r_q;
    logic [7:0]  r_out  [3];

    logic [31:0] w_sel_acc, w_sel_scl, w_max01, w_max, w_scaled, w_norm;
    logic [42:0] w_mul;
    logic [31:0] w_start;
    logic        w_ge;

    always_comb begin
        case (i_cmd.ch)
            2'd1:    begin w_sel_acc = r_acc[1]; w_sel_scl = r_scl[1]; end
            2'd2:    begin w_sel_acc = r_acc[2]; w_sel_scl = r_scl[2]; end
            default: begin w_sel_acc = r_acc[0]; w_sel_scl = r_scl[0]; end
        endcase
    end

    // Output scale, capped at 255.5 in 16.16 shifted left by 8
    assign w_mul    = 43'(w_sel_acc) * 43'(i_cfg.out_scale);
    assign w_scaled = (w_mul > 43'(SCALED_CAP)) ? SCALED_CAP : w_mul[31:0];

    assign w_max01 = (r_scl[0] > r_scl[1]) ? r_scl[0] : r_scl[1];
    assign w_max   = (w_max01 > r_scl[2]) ? w_max01 : r_scl[2];

    assign w_ge   = {8'b0, r_rem} >= r_dsh;
    assign w_norm = 32'(w_sel_scl[31:8]) * 32'(r_q);

    assign o_status.last      = r_last;
    assign o_status.need_norm = w_max > NORM_LIMIT;

    // Start value of a texel in the current (or newly written) mode
    assign w_start = (i_cfg.fb_load ? i_cfg.fb_new : i_cfg.fullbright) ? START_FULL : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 3; c++) r_acc[c] <= '0;
        end else begin
            for (int c = 0; c < 3; c++) begin
                if (i_cfg.fb_load || i_cmd.load_out) begin
                    r_acc[c] <= w_start;
                end else if (i_cmd.add_prod && !i_cfg.fullbright) begin
                    r_acc[c] <= sat_add(r_acc[c], 32'(r_prod[c]));
                end else if (i_cmd.add_dyn && !i_cfg.fullbright) begin
                    r_acc[c] <= sat_add(r_acc[c], 32'(r_dyn[c]));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[c] <= 20'(i_sample[c]) * 20'(i_style_scale);
                r_dyn[c]  <= i_dyn[c];
            end
            r_last <= i_last;
        end
        for (int c = 0; c < 3; c++) begin
            if (i_cmd.scale && i_cmd.ch == 2'(c)) r_scl[c] <= w_scaled;
            if (i_cmd.norm && i_cmd.ch == 2'(c))  r_scl[c] <= w_norm;
            if (i_cmd.load_out) r_out[c] <= r_scl[c][23:16] ^ {8{i_cfg.invert}};
        end
        // Restoring divide of the cap by the largest channel, one bit a cycle
        if (i_cmd.load_div) begin
            r_rem <= SCALED_CAP;
            r_dsh <= {w_max, 8'b0} >> 1;
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            if (w_ge) r_rem <= r_rem - r_dsh[31:0];
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[6:0], w_ge};
        end
    end

    assign o_out = r_out;

endmodule

`default_nettype wire

/* hdl/lightmap_texel_combine.sv */
// Top level of the lightmap texel combiner: register port, controller, datapath.
//
// Usage: one item on i_lyr per light-style layer of a texel. The layer with
// last_layer set closes the texel and produces one item on o_tex; other
// layers produce nothing. The APB-style port holds output_scale (0x0),
// invert_output (0x4) and fullbright (0x8); write them only while idle.
// Writing fullbright reloads the accumulators and drops a partial texel.
// Sequence: a layer that is not last is captured, then one saturating add
// runs. A last layer also adds the dynamic light, then scales each channel;
// if the largest scaled channel exceeds 255.5, the 8-step restoring divider
// and a per-channel rescale run; the shared 32x11 scale multiplier handles
// one channel a cycle. The next layer is taken only after the emit step.
// Reset (synchronous, active low) restores output_scale 512, invert 1,
// fullbright 0 and clears the accumulators and the o_tex valid flag.
// Output register: a finished texel waits there while the next layers are
// taken; a new texel stalls in its emit step only while o_tex is still full.
`timescale 1ns / 1ps
`default_nettype none

module lightmap_texel_combine (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    ltc_layer_if.sink                       i_lyr,
    ltc_texel_if.source                     o_tex,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [ltc_pkg::ADDR_W-1:0] paddr,
    input  wire logic [ltc_pkg::DATA_W-1:0] pwdata,
    output logic [ltc_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import ltc_pkg::*;

    // Configuration registers
    logic [10:0] r_out_scale;
    logic        r_invert;
    logic        r_fb_mode;
    logic        w_wr;
    logic [1:0]  w_idx;

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_scale <= OUT_SCALE_RST;
            r_invert    <= 1'b1;
            r_fb_mode   <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                REG_OUT_SCALE:  r_out_scale <= pwdata[10:0];
                REG_INVERT:     r_invert    <= pwdata[0];
                REG_FULLBRIGHT: r_fb_mode   <= pwdata[0];
                default:        ;   // ignore writes beyond the register list
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_OUT_SCALE:  prdata = 32'(r_out_scale);
            REG_INVERT:     prdata = 32'(r_invert);
            REG_FULLBRIGHT: prdata = 32'(r_fb_mode);
            default:        prdata = '0;
        endcase
    end

    // Settings seen by the datapath; fb_load reloads the accumulators
    t_cfg w_cfg;
    assign w_cfg.out_scale  = r_out_scale;
    assign w_cfg.invert     = r_invert;
    assign w_cfg.fullbright = r_fb_mode;
    assign w_cfg.fb_load    = w_wr && (w_idx == REG_FULLBRIGHT);
    assign w_cfg.fb_new     = pwdata[0];

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic [7:0]  w_sample [3];
    logic [23:0] w_dyn    [3];
    logic [7:0]  w_out    [3];

    assign w_sample[0] = i_lyr.sample_r;
    assign w_sample[1] = i_lyr.sample_g;
    assign w_sample[2] = i_lyr.sample_b;
    assign w_dyn[0]    = i_lyr.dyn_r;
    assign w_dyn[1]    = i_lyr.dyn_g;
    assign w_dyn[2]    = i_lyr.dyn_b;

    ltc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_lyr.valid),
        .o_in_ready  (i_lyr.ready),
        .o_out_valid (o_tex.valid),
        .i_out_ready (o_tex.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    ltc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg         (w_cfg),
        .i_sample      (w_sample),
        .i_style_scale (i_lyr.style_scale),
        .i_dyn         (w_dyn),
        .i_last        (i_lyr.last_layer),
        .o_out         (w_out)
    );

    // Hold the finished texel item on the output channel
    assign o_tex.out_r = w_out[0];
    assign o_tex.out_g = w_out[1];
    assign o_tex.out_b = w_out[2];

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the lightmap texel combiner: layer driver, texel monitor.
`timescale 1ns / 1ps

module testbench;

    import ltc_pkg::*;

    // Fixed-point limits of the overbright normalize step
    localparam logic [31:0] TEXEL_FULL  = 32'h0000_FF00;
    localparam logic [63:0] PEAK_LIMIT  = 64'h0000_0000_00FF_8000;
    localparam logic [63:0] PRODUCT_CAP = 64'h0000_0000_FF80_0000;
    localparam logic [31:0] ACC_MAX     = 32'hFFFF_FFFF;
    localparam logic [1:0]  REG_SPARE   = 2'd3;     // no register behind this index
    localparam int          SETTLE_CYC  = 24;       // longest layer latency plus margin
    localparam int          DRAIN_CYC   = 4000;
    localparam longint      TIMEOUT_NS  = 64'd6_000_000;

    typedef struct packed {
        logic [7:0]  sample_r;
        logic [7:0]  sample_g;
        logic [7:0]  sample_b;
        logic [11:0] style_scale;
        logic [23:0] dyn_r;
        logic [23:0] dyn_g;
        logic [23:0] dyn_b;
        logic        last_layer;
    } t_layer;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_texel;

    typedef enum int { MIX_RANDOM, MIX_DIM, MIX_EXTREME, MIX_NORMAL } t_mix;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    ltc_layer_if lyr_if ();
    ltc_texel_if tex_if ();

    lightmap_texel_combine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lyr   (lyr_if),
        .o_tex   (tex_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the block: registers and the three light accumulators
    logic [10:0] cfg_scale;
    logic        cfg_invert;
    logic        cfg_fullbright;
    logic [31:0] acc_r;
    logic [31:0] acc_g;
    logic [31:0] acc_b;

    t_layer layer_q[$];            // layers waiting for the driver
    t_texel expected_texels[$];    // texels predicted, not yet seen on o_tex
    t_layer drv_layer;             // layer currently offered on i_lyr
    int     src_hold;
    int     snk_hold;
    int     src_pct;               // chance per free slot that the sender pauses
    int     snk_pct;               // chance per cycle that the receiver stalls
    int     mismatches;

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = 64'(a) + b;
        return (s > 64'(ACC_MAX)) ? ACC_MAX : s[31:0];
    endfunction

    // Multiply by the overbright scale, clamp at 255.5 in 16.16 shifted by 8
    function automatic logic [63:0] overbright(input logic [31:0] acc);
        logic [63:0] p;
        p = 64'(acc) * 64'(cfg_scale);
        return (p > PRODUCT_CAP) ? PRODUCT_CAP : p;
    endfunction

    function automatic logic [7:0] texel_byte(input logic [63:0] v);
        return cfg_invert ? 8'd255 - v[23:16] : v[23:16];
    endfunction

    function automatic void restart_texel();
        acc_r = cfg_fullbright ? TEXEL_FULL : 32'd0;
        acc_g = cfg_fullbright ? TEXEL_FULL : 32'd0;
        acc_b = cfg_fullbright ? TEXEL_FULL : 32'd0;
    endfunction

    // Fold one accepted layer into the texel; a last layer yields the texel
    function automatic void blend_layer(input t_layer it);
        logic [63:0] r;
        logic [63:0] g;
        logic [63:0] b;
        logic [63:0] peak;
        logic [63:0] ratio;
        t_texel      t;
        if (!cfg_fullbright) begin
            acc_r = sat_sum(acc_r, 64'(it.sample_r) * 64'(it.style_scale));
            acc_g = sat_sum(acc_g, 64'(it.sample_g) * 64'(it.style_scale));
            acc_b = sat_sum(acc_b, 64'(it.sample_b) * 64'(it.style_scale));
        end
        if (!it.last_layer) begin
            return;
        end
        if (!cfg_fullbright) begin
            acc_r = sat_sum(acc_r, 64'(it.dyn_r));
            acc_g = sat_sum(acc_g, 64'(it.dyn_g));
            acc_b = sat_sum(acc_b, 64'(it.dyn_b));
        end
        r = overbright(acc_r);
        g = overbright(acc_g);
        b = overbright(acc_b);
        peak = (r > g) ? r : g;
        peak = (peak > b) ? peak : b;
        if (peak > PEAK_LIMIT) begin
            ratio = PRODUCT_CAP / peak;
            r = (r >> 8) * ratio;
            g = (g >> 8) * ratio;
            b = (b >> 8) * ratio;
        end
        t.r = texel_byte(r);
        t.g = texel_byte(g);
        t.b = texel_byte(b);
        expected_texels.push_back(t);
        restart_texel();
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic void add_layer(input logic [7:0] sr, input logic [7:0] sg,
                                      input logic [7:0] sb, input logic [11:0] sc,
                                      input logic [23:0] dr, input logic [23:0] dg,
                                      input logic [23:0] db, input logic last);
        t_layer it;
        it = '{sr, sg, sb, sc, dr, dg, db, last};
        layer_q.push_back(it);
    endfunction

    function automatic logic [23:0] pick_extreme(input logic [23:0] top);
        case ($urandom_range(0, 2))
            0: return 24'd0;
            1: return top;
            default: return 24'($urandom_range(0, top));
        endcase
    endfunction

    function automatic t_layer make_layer(input t_mix mix, input logic last);
        t_layer it;
        it.sample_r    = 8'($urandom);
        it.sample_g    = 8'($urandom);
        it.sample_b    = 8'($urandom);
        it.style_scale = 12'($urandom);
        it.dyn_r       = 24'($urandom);
        it.dyn_g       = 24'($urandom);
        it.dyn_b       = 24'($urandom);
        case (mix)
            MIX_DIM: begin
                // small sums: a one-layer texel stays below the normalize threshold at scale 512
                it.style_scale = 12'($urandom_range(0, 64));
                it.dyn_r       = 24'($urandom_range(0, 4095));
                it.dyn_g       = 24'($urandom_range(0, 4095));
                it.dyn_b       = 24'($urandom_range(0, 4095));
            end
            MIX_EXTREME: begin
                it.sample_r    = 8'(pick_extreme(24'hFF));
                it.sample_g    = 8'(pick_extreme(24'hFF));
                it.sample_b    = 8'(pick_extreme(24'hFF));
                it.style_scale = 12'(pick_extreme(24'hFFF));
                it.dyn_r       = pick_extreme(24'hFF_FFFF);
                it.dyn_g       = pick_extreme(24'hFF_FFFF);
                it.dyn_b       = pick_extreme(24'hFF_FFFF);
            end
            MIX_NORMAL: begin
                it.style_scale = 12'($urandom_range(192, 320));
                it.dyn_r       = 24'($urandom_range(0, 1 << 20));
                it.dyn_g       = 24'($urandom_range(0, 1 << 20));
                it.dyn_b       = 24'($urandom_range(0, 1 << 20));
            end
            default: ;
        endcase
        it.last_layer = last;
        return it;
    endfunction

    // Queue whole texels of random depth, sometimes ending on dangling layers
    function automatic void queue_texels(input int n);
        int   count;
        int   depth;
        t_mix mix;
        count = 0;
        while (count < n) begin
            mix   = t_mix'($urandom_range(0, 3));
            depth = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 3);
            for (int i = 0; i < depth; i++) begin
                layer_q.push_back(make_layer(mix, i == depth - 1));
                count++;
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            depth = $urandom_range(1, 3);
            for (int i = 0; i < depth; i++) begin
                layer_q.push_back(make_layer(MIX_RANDOM, 1'b0));
            end
        end
    endfunction

    // APB write: setup cycle, access cycle, then release the bus
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_OUT_SCALE:  cfg_scale = val[10:0];
            REG_INVERT:     cfg_invert = val[0];
            REG_FULLBRIGHT: begin
                cfg_fullbright = val[0];
                restart_texel();
            end
            default: ;
        endcase
    endtask

    // Wait until every layer is taken and every texel is out, then let the
    // datapath finish any trailing add before the next register write
    task automatic settle();
        int waited;
        waited = 0;
        while (layer_q.size() != 0 || lyr_if.valid) begin
            @(posedge i_clk);
        end
        while (expected_texels.size() != 0 && waited < DRAIN_CYC) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_texels.size() != 0) begin
            $display("%0t: %0d texel item(s) never arrived, next expected r=%0d g=%0d b=%0d",
                     $time, expected_texels.size(), expected_texels[0].r,
                     expected_texels[0].g, expected_texels[0].b);
            mismatches++;
            expected_texels.delete();
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [10:0] scale, input logic inv, input logic fb,
                             input int src_p, input int snk_p, input int n);
        logic [31:0] junk;
        settle();
        // garbage above the register width must be dropped by the block
        junk = ($urandom_range(0, 2) == 0) ? $urandom : 32'd0;
        write_reg(REG_OUT_SCALE, {junk[31:11], scale});
        write_reg(REG_INVERT, {junk[31:1], inv});
        if (fb != cfg_fullbright || $urandom_range(0, 1) == 1) begin
            write_reg(REG_FULLBRIGHT, {junk[31:1], fb});
        end
        src_pct = src_p;
        snk_pct = snk_p;
        queue_texels(n);
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // ---------------------------------------------------------------
    // Clock, driver, receiver, monitor
    // ---------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Layer driver: hold an offered item until taken, pause in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lyr_if.valid <= 1'b0;
            src_hold     <= 0;
        end else begin
            if (lyr_if.valid && lyr_if.ready) begin
                blend_layer(drv_layer);
            end
            if (!lyr_if.valid || lyr_if.ready) begin
                if (src_hold != 0) begin
                    src_hold     <= src_hold - 1;
                    lyr_if.valid <= 1'b0;
                end else if (src_pct != 0 && $urandom_range(0, 99) < src_pct) begin
                    src_hold     <= $urandom_range(0, 17);
                    lyr_if.valid <= 1'b0;
                end else if (layer_q.size() != 0) begin
                    drv_layer = layer_q.pop_front();
                    lyr_if.sample_r    <= drv_layer.sample_r;
                    lyr_if.sample_g    <= drv_layer.sample_g;
                    lyr_if.sample_b    <= drv_layer.sample_b;
                    lyr_if.style_scale <= drv_layer.style_scale;
                    lyr_if.dyn_r       <= drv_layer.dyn_r;
                    lyr_if.dyn_g       <= drv_layer.dyn_g;
                    lyr_if.dyn_b       <= drv_layer.dyn_b;
                    lyr_if.last_layer  <= drv_layer.last_layer;
                    lyr_if.valid       <= 1'b1;
                end else begin
                    lyr_if.valid <= 1'b0;
                end
            end
        end
    end

    // Texel receiver: stall in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tex_if.ready <= 1'b0;
            snk_hold     <= 0;
        end else if (snk_hold != 0) begin
            snk_hold     <= snk_hold - 1;
            tex_if.ready <= 1'b0;
        end else if (snk_pct != 0 && $urandom_range(0, 99) < snk_pct) begin
            snk_hold     <= $urandom_range(0, 17);
            tex_if.ready <= 1'b0;
        end else begin
            tex_if.ready <= 1'b1;
        end
    end

    // Monitor: compare each texel item taken with the oldest prediction
    always @(posedge i_clk) begin
        t_texel want;
        if (i_rst_n && tex_if.valid && tex_if.ready) begin
            if (expected_texels.size() == 0) begin
                $display("%0t: unexpected texel item, expected none actual r=%0d g=%0d b=%0d",
                         $time, tex_if.out_r, tex_if.out_g, tex_if.out_b);
                mismatches++;
            end else begin
                want = expected_texels.pop_front();
                check_field("out_r", want.r, tex_if.out_r);
                check_field("out_g", want.g, tex_if.out_g);
                check_field("out_b", want.b, tex_if.out_b);
            end
        end
    end

    // Hard stop for a hung handshake
    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------

    initial begin
        // Drive every input to a known level before the first edge
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        lyr_if.valid       = 1'b0;
        lyr_if.sample_r    = '0;
        lyr_if.sample_g    = '0;
        lyr_if.sample_b    = '0;
        lyr_if.style_scale = '0;
        lyr_if.dyn_r       = '0;
        lyr_if.dyn_g       = '0;
        lyr_if.dyn_b       = '0;
        lyr_if.last_layer  = 1'b0;
        tex_if.ready       = 1'b0;
        src_pct            = 15;
        snk_pct            = 15;
        mismatches         = 0;

        // Shadow registers start at their reset values
        cfg_scale      = 11'd512;
        cfg_invert     = 1'b1;
        cfg_fullbright = 1'b0;
        restart_texel();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed layers under the reset settings (scale 512, inverted)
        add_layer(8'd0, 8'd0, 8'd0, 12'd0, 24'd0, 24'd0, 24'd0, 1'b1);
        add_layer(8'hFF, 8'hFF, 8'hFF, 12'hFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1'b1);
        add_layer(8'd255, 8'd0, 8'd128, 12'd256, 24'd0, 24'd0, 24'd0, 1'b1);
        add_layer(8'd1, 8'd1, 8'd1, 12'd1, 24'd0, 24'd0, 24'd0, 1'b1);
        // three-layer texel; dyn on the early layers must be ignored
        add_layer(8'd200, 8'd100, 8'd50, 12'd256, 24'hFF_FFFF, 24'd7, 24'h80_0000, 1'b0);
        add_layer(8'd10, 8'd20, 8'd30, 12'd512, 24'd1234, 24'hFF_FFFF, 24'd9, 1'b0);
        add_layer(8'd0, 8'd0, 8'd0, 12'd0, 24'd1000, 24'd2000, 24'd3000, 1'b1);
        add_layer(8'd0, 8'd0, 8'd0, 12'hFFF, 24'hFF_FFFF, 24'd0, 24'd0, 1'b1);
        add_layer(8'hAA, 8'h55, 8'hAA, 12'hAAA, 24'hAA_AAAA, 24'h55_5555, 24'hAA_AAAA, 1'b1);
        add_layer(8'h55, 8'hAA, 8'h55, 12'h555, 24'h55_5555, 24'hAA_AAAA, 24'h55_5555, 1'b1);
        // zero brightness layer followed by one with zero samples at full scale
        add_layer(8'd255, 8'd255, 8'd255, 12'd0, 24'd0, 24'd0, 24'd0, 1'b0);
        add_layer(8'd0, 8'd0, 8'd0, 12'hFFF, 24'd0, 24'd0, 24'd0, 1'b1);
        // dim texel, no normalize
        add_layer(8'd100, 8'd50, 8'd10, 12'd32, 24'd100, 24'd200, 24'd300, 1'b1);
        // strong hue, normalize keeps the ratio
        add_layer(8'd255, 8'd128, 8'd1, 12'd1024, 24'd0, 24'd0, 24'd0, 1'b1);
        // peak exactly on the normalize threshold, then one step above it
        add_layer(8'd128, 8'd128, 8'd128, 12'd255, 24'd64, 24'd64, 24'd63, 1'b1);
        add_layer(8'd128, 8'd128, 8'd128, 12'd255, 24'd65, 24'd64, 24'd63, 1'b1);
        // dangling layer; a fullbright write may drop it
        add_layer(8'd50, 8'd60, 8'd70, 12'd300, 24'd5, 24'd5, 24'd5, 1'b0);

        // Random phases across the register space
        run_phase(11'd384, 1'b0, 1'b0, 10, 10, 180);
        run_phase(11'd0, 1'b1, 1'b0, 20, 5, 170);

        // Unit scale: a deep texel stacks many bright layers
        run_phase(11'd1, 1'b0, 1'b0, 5, 5, 150);
        for (int i = 0; i < 40; i++) begin
            add_layer(8'd255, 8'd0, 8'd128, 12'hFFF, 24'd0, 24'd0, 24'd0, 1'b0);
        end
        add_layer(8'd255, 8'd0, 8'd128, 12'hFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 1'b1);

        run_phase(11'd1536, 1'b0, 1'b0, 0, 30, 180);
        run_phase(11'd2047, 1'b1, 1'b0, 30, 0, 170);
        run_phase(11'($urandom_range(2, 1535)), 1'($urandom), 1'b0, 10, 10, 200);
        run_phase(11'd512, 1'b0, 1'b1, 10, 10, 150);
        run_phase(11'd0, 1'b1, 1'b1, 5, 20, 100);

        // Spare index: write must leave every register alone
        settle();
        write_reg(REG_SPARE, $urandom);
        run_phase(11'd256, 1'b1, 1'b0, 0, 0, 180);
        run_phase(11'($urandom_range(2, 1535)), 1'($urandom), 1'b0, 15, 15, 200);

        // Closing stretch at full rate on both sides
        run_phase(11'd768, 1'b0, 1'b0, 0, 0, 200);

        settle();
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
